// ===== rtl/ctc_pkg.sv =====
// shared types, codes and constants for the compare match timer
package ctc_pkg;

    // counter width inside the block, 8 to 16
    localparam int COUNT_WIDTH     = 16;
    // port widths fixed by the interface
    localparam int VALUE_WIDTH     = 16;
    localparam int SELECT_WIDTH    = 3;
    localparam int KIND_WIDTH      = 3;
    localparam int REPEAT_WIDTH    = 32;
    localparam int PRESCALE_WIDTH  = 10;
    localparam int INDEX_WIDTH     = 1;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_TICK   = 3'd0,
        KIND_PAUSE  = 3'd1,
        KIND_RESUME = 3'd2,
        KIND_ARM    = 3'd3,
        KIND_DISARM = 3'd4
    } kind_t;

    typedef enum logic [SELECT_WIDTH-1:0] {
        SEL_STOP    = 3'd0,
        SEL_DIV1    = 3'd1,
        SEL_DIV8    = 3'd2,
        SEL_DIV64   = 3'd3,
        SEL_DIV256  = 3'd4,
        SEL_DIV1024 = 3'd5
    } sel_t;

    localparam logic [INDEX_WIDTH-1:0] REG_COMPARE  = 1'd0;
    localparam logic [INDEX_WIDTH-1:0] REG_PRESCALE = 1'd1;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0]  compare;
        logic [SELECT_WIDTH-1:0] select;
    } cfg_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]   kind;
        logic [REPEAT_WIDTH-1:0] count;
    } req_t;

    typedef struct packed {
        logic                      stopped;
        logic [PRESCALE_WIDTH-1:0] top;
    } step_t;

    // last prescaler step for a select; unused selects are stopped
    function automatic step_t last_step(logic [SELECT_WIDTH-1:0] sel);
        step_t s;
        s.stopped = 1'b0;
        s.top     = '0;
        unique case (sel)
            SEL_DIV1:    s.top = 10'd0;
            SEL_DIV8:    s.top = 10'd7;
            SEL_DIV64:   s.top = 10'd63;
            SEL_DIV256:  s.top = 10'd255;
            SEL_DIV1024: s.top = 10'd1023;
            default:     s.stopped = 1'b1;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/ctc_cfg_regs.sv =====
// configuration registers: compare value and prescaler select
module ctc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ctc_pkg::INDEX_WIDTH-1:0]  cfg_index,
    input  logic [ctc_pkg::VALUE_WIDTH-1:0]  cfg_data,
    output ctc_pkg::cfg_t                    cfg
);
    import ctc_pkg::*;

    logic [COUNT_WIDTH-1:0]  compare_reg;
    logic [SELECT_WIDTH-1:0] select_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_reg <= '1;
            select_reg  <= SEL_DIV1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COMPARE:  compare_reg <= cfg_data[COUNT_WIDTH-1:0];
                REG_PRESCALE: select_reg  <= cfg_data[SELECT_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg.compare = compare_reg;
    assign cfg.select  = select_reg;

endmodule

// ===== rtl/ctc_in_reg.sv =====
// input register stage for requests
module ctc_in_reg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ctc_pkg::KIND_WIDTH-1:0]    kind,
    input  logic signed [ctc_pkg::REPEAT_WIDTH-1:0] arm_count,
    input  logic                              take,
    output logic                              req_valid,
    output ctc_pkg::req_t                     req
);
    import ctc_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    // slot frees up when the core takes the held request
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.kind  <= kind;
            req_reg.count <= arm_count;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

// ===== rtl/ctc_core.sv =====
// timer state, next-state logic and result register
module ctc_core (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  ctc_pkg::cfg_t                            cfg,
    input  logic                                     req_valid,
    input  ctc_pkg::req_t                            req,
    output logic                                     take,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     fire,
    output logic                                     done_res,
    output logic [ctc_pkg::VALUE_WIDTH-1:0]          counter_value,
    output logic signed [ctc_pkg::REPEAT_WIDTH-1:0]  remaining,
    output logic                                     armed
);
    import ctc_pkg::*;

    logic [PRESCALE_WIDTH-1:0] pre_reg,  pre_next;
    logic [COUNT_WIDTH-1:0]    cnt_reg,  cnt_next;
    logic [REPEAT_WIDTH-1:0]   rep_reg,  rep_next;
    logic                      en_reg,   en_next;
    logic                      run_reg,  run_next;

    logic                      res_valid_reg, res_valid_next;
    logic                      fire_reg, fire_next;
    logic                      done_reg, done_next;

    logic                      core_ready;
    logic                      advance;
    step_t                     step;

    assign core_ready = !res_valid_reg || out_ready;
    assign take       = req_valid && core_ready;
    assign step       = last_step(cfg.select);

    always_comb
    begin
        pre_next  = pre_reg;
        cnt_next  = cnt_reg;
        rep_next  = rep_reg;
        en_next   = en_reg;
        run_next  = run_reg;
        fire_next = 1'b0;
        done_next = 1'b0;
        advance   = 1'b0;
        unique case (req.kind)
            KIND_TICK:
            begin
                if (run_reg && !step.stopped)
                begin
                    // overshoot after a select change also lands here
                    if (pre_reg >= step.top)
                    begin
                        pre_next = '0;
                        advance  = 1'b1;
                    end
                    else
                    begin
                        pre_next = pre_reg + 1'b1;
                    end
                end
                if (advance)
                begin
                    if (cnt_reg == cfg.compare)
                    begin
                        cnt_next = '0;
                        if (en_reg)
                        begin
                            if (rep_reg != '0)
                            begin
                                fire_next = 1'b1;
                                // negative counts repeat forever
                                if (!rep_reg[REPEAT_WIDTH-1])
                                begin
                                    rep_next = rep_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                en_next   = 1'b0;
                                done_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            KIND_PAUSE:  run_next = 1'b0;
            KIND_RESUME: run_next = 1'b1;
            KIND_ARM:
            begin
                rep_next = req.count;
                en_next  = 1'b1;
            end
            KIND_DISARM: en_next = 1'b0;
            default:     ;
        endcase
    end

    assign res_valid_next = core_ready ? req_valid : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg       <= '0;
            cnt_reg       <= '0;
            rep_reg       <= '1;
            en_reg        <= 1'b0;
            run_reg       <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                pre_reg <= pre_next;
                cnt_reg <= cnt_next;
                rep_reg <= rep_next;
                en_reg  <= en_next;
                run_reg <= run_next;
            end
        end
    end

    // result flags; counter, count and arm state read straight from the state
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fire_reg <= fire_next;
            done_reg <= done_next;
        end
    end

    assign out_valid     = res_valid_reg;
    assign fire          = fire_reg;
    assign done_res      = done_reg;
    assign counter_value = VALUE_WIDTH'(cnt_reg);
    assign remaining     = rep_reg;
    assign armed         = en_reg;

endmodule

// ===== rtl/ctc_timer_with_repeat_count.sv =====
// top level of the prescaled compare match timer with repeat count
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------------
//   input    | in_valid / in_ready   | kind, arm_count
//   result   | out_valid / out_ready | fire, done_res, counter_value, remaining, armed
//   config   | cfg_write             | cfg_index, cfg_data
//
// one request per cycle while results are taken; a result is valid once its accepted request has passed
// the input register and then the state update into the result register
// the state update is a single 32-bit decrement and a 16-bit compare per cycle
// reset: counter and prescaler 0, remaining -1, disarmed, running; no clearing pass
// a stalled result holds the core; the input register still takes one more request
module ctc_timer_with_repeat_count (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [ctc_pkg::INDEX_WIDTH-1:0]          cfg_index,
    input  logic [ctc_pkg::VALUE_WIDTH-1:0]          cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [ctc_pkg::KIND_WIDTH-1:0]           kind,
    input  logic signed [ctc_pkg::REPEAT_WIDTH-1:0]  arm_count,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     fire,
    output logic                                     done_res,
    output logic [ctc_pkg::VALUE_WIDTH-1:0]          counter_value,
    output logic signed [ctc_pkg::REPEAT_WIDTH-1:0]  remaining,
    output logic                                     armed
);
    import ctc_pkg::*;

    cfg_t cfg;
    req_t req;
    logic req_valid;
    logic take;

    ctc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ctc_in_reg u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .arm_count (arm_count),
        .take      (take),
        .req_valid (req_valid),
        .req       (req)
    );

    ctc_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .req_valid     (req_valid),
        .req           (req),
        .take          (take),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fire          (fire),
        .done_res      (done_res),
        .counter_value (counter_value),
        .remaining     (remaining),
        .armed         (armed)
    );

`ifndef SYNTHESIS
    // a match either fires or finishes, never both
    a_fire_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(fire && done_res))
        else $error("fire and done_res both set");

    // finishing always leaves the timer disarmed
    a_done_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !armed)
        else $error("done_res with timer still armed");

    // a draining result side never blocks new requests
    a_ready_flows: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while results drain");

    // a fire from a finite count leaves it one lower, never negative
    a_fire_count: assert property (@(posedge clk) disable iff (!rst_n)
        (take && u_core.fire_next && !u_core.rep_reg[REPEAT_WIDTH-1])
        |=> !remaining[REPEAT_WIDTH-1])
        else $error("finite repeat count went negative");
`endif

endmodule

// ===== bench/tb_ctc_timer_with_repeat_count.sv =====
// self-checking testbench for the prescaled compare match timer with repeat count
module tb_ctc_timer_with_repeat_count;

    import ctc_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_CHUNK   = 70;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [KIND_WIDTH-1:0]   KIND_TOP_CODE = '1;
    localparam logic [SELECT_WIDTH-1:0] SEL_SPARE     = 3'd6;
    localparam logic [SELECT_WIDTH-1:0] SEL_TOP_CODE  = '1;

    typedef struct packed {
        logic                    fire;
        logic                    done;
        logic [VALUE_WIDTH-1:0]  count;
        logic [REPEAT_WIDTH-1:0] left;
        logic                    armed;
    } timer_view_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [INDEX_WIDTH-1:0]         cfg_index = '0;
    logic [VALUE_WIDTH-1:0]         cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [KIND_WIDTH-1:0]          kind = '0;
    logic signed [REPEAT_WIDTH-1:0] arm_count = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           fire;
    logic                           done_res;
    logic [VALUE_WIDTH-1:0]         counter_value;
    logic signed [REPEAT_WIDTH-1:0] remaining;
    logic                           armed;

    // timer mirror
    logic [COUNT_WIDTH-1:0]    cfg_compare = '1;
    logic [SELECT_WIDTH-1:0]   cfg_sel = SEL_DIV1;
    logic [PRESCALE_WIDTH-1:0] prescale_now = '0;
    logic [COUNT_WIDTH-1:0]    count_now = '0;
    logic [REPEAT_WIDTH-1:0]   left_now = '1;
    logic                      armed_now = 1'b0;
    logic                      running_now = 1'b1;

    timer_view_t pending_views[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          stall_burst = 0;
    int          quiet_cycles = 0;

    ctc_timer_with_repeat_count u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .arm_count     (arm_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fire          (fire),
        .done_res      (done_res),
        .counter_value (counter_value),
        .remaining     (remaining),
        .armed         (armed)
    );

    always #6 clk = ~clk;

    function automatic timer_view_t step_timer(input logic [KIND_WIDTH-1:0] k,
                                               input logic [REPEAT_WIDTH-1:0] c);
        timer_view_t v;
        int unsigned divider;
        logic        bump;
        v.fire  = 1'b0;
        v.done  = 1'b0;
        bump    = 1'b0;
        divider = 0;
        case (k)
            KIND_TICK:
            begin
                case (cfg_sel)
                    SEL_DIV1:    divider = 1;
                    SEL_DIV8:    divider = 8;
                    SEL_DIV64:   divider = 64;
                    SEL_DIV256:  divider = 256;
                    SEL_DIV1024: divider = 1024;
                    default:     divider = 0;
                endcase
                if (running_now && divider != 0)
                begin
                    // a switch to a shorter divider can leave the prescaler past its end
                    if (prescale_now >= divider - 1)
                    begin
                        prescale_now = '0;
                        bump = 1'b1;
                    end
                    else
                    begin
                        prescale_now = prescale_now + 1'b1;
                    end
                end
                if (bump)
                begin
                    if (count_now == cfg_compare)
                    begin
                        count_now = '0;
                        if (armed_now)
                        begin
                            if (left_now != '0)
                            begin
                                v.fire = 1'b1;
                                // any negative count repeats forever
                                if (!left_now[REPEAT_WIDTH-1])
                                    left_now = left_now - 1'b1;
                            end
                            else
                            begin
                                armed_now = 1'b0;
                                v.done = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        count_now = count_now + 1'b1;
                    end
                end
            end
            KIND_PAUSE:  running_now = 1'b0;
            KIND_RESUME: running_now = 1'b1;
            KIND_ARM:
            begin
                left_now = c;
                armed_now = 1'b1;
            end
            KIND_DISARM: armed_now = 1'b0;
            default: ;
        endcase
        v.count = VALUE_WIDTH'(count_now);
        v.left  = left_now;
        v.armed = armed_now;
        return v;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result side: random stalls, an optional long hold, and the compare
    always @(posedge clk)
    begin : result_monitor
        timer_view_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_views.size() == 0)
            begin
                $display("%0t: expected no result, actual fire=%0b done=%0b",
                         $time, fire, done_res);
                mismatches++;
            end
            else
            begin
                want = pending_views.pop_front();
                check_field("fire", 32'(want.fire), 32'(fire));
                check_field("done_res", 32'(want.done), 32'(done_res));
                check_field("counter_value", 32'(want.count), 32'(counter_value));
                check_field("remaining", want.left, remaining);
                check_field("armed", 32'(want.armed), 32'(armed));
            end
        end
        if (stall_burst > 0)
        begin
            stall_burst--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_ctc_timer_with_repeat_count failed");
                $finish;
            end
        end
    end

    // valid stays up between back-to-back requests; an idle gap lowers it first
    task automatic send_request(input logic [KIND_WIDTH-1:0] k,
                                input logic [REPEAT_WIDTH-1:0] c);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        arm_count <= c;
        do
            @(posedge clk);
        while (!in_ready);
        pending_views.push_back(step_timer(k, c));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_WIDTH-1:0] idx,
                             input logic [VALUE_WIDTH-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == REG_COMPARE)
            cfg_compare = data[COUNT_WIDTH-1:0];
        else
            cfg_sel = data[SELECT_WIDTH-1:0];
    endtask

    task automatic configure(input logic [VALUE_WIDTH-1:0] top,
                             input logic [VALUE_WIDTH-1:0] sel_word);
        write_reg(REG_COMPARE, top);
        write_reg(REG_PRESCALE, sel_word);
    endtask

    function automatic logic [REPEAT_WIDTH-1:0] pick_repeats();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return REPEAT_WIDTH'($urandom_range(4));
        else if (r < 60)
            return '1;
        else if (r < 70)
            return $urandom() | 32'h8000_0000;
        else
            return $urandom();
    endfunction

    task automatic send_random_request();
        int                      r;
        logic [KIND_WIDTH-1:0]   k;
        logic [REPEAT_WIDTH-1:0] c;
        r = $urandom_range(99);
        c = $urandom();
        if (r < 72)
            k = KIND_TICK;
        else if (r < 80)
        begin
            k = KIND_ARM;
            c = pick_repeats();
        end
        else if (r < 85)
            k = KIND_DISARM;
        else if (r < 89)
            k = KIND_PAUSE;
        else if (r < 96)
            k = KIND_RESUME;
        else
            k = KIND_WIDTH'($urandom_range(KIND_DISARM + 1, KIND_TOP_CODE));
        send_request(k, c);
    endtask

    // mostly short periods at fast dividers so that matches stay frequent
    task automatic random_settings();
        int                     r;
        logic [VALUE_WIDTH-1:0] top;
        logic [VALUE_WIDTH-1:0] sel_word;
        r = $urandom_range(99);
        if (r < 55)
            top = VALUE_WIDTH'($urandom_range(7));
        else if (r < 80)
            top = VALUE_WIDTH'($urandom_range(63));
        else if (r < 88)
            top = '0;
        else if (r < 94)
            top = '1;
        else
            top = VALUE_WIDTH'($urandom());
        sel_word = VALUE_WIDTH'($urandom());
        r = $urandom_range(99);
        if (r < 55)
            sel_word[SELECT_WIDTH-1:0] = SEL_DIV1;
        else if (r < 75)
            sel_word[SELECT_WIDTH-1:0] = SEL_DIV8;
        else if (r < 88)
            sel_word[SELECT_WIDTH-1:0] = SELECT_WIDTH'($urandom_range(SEL_DIV64, SEL_DIV1024));
        else
            sel_word[SELECT_WIDTH-1:0] = SELECT_WIDTH'($urandom_range(SEL_STOP, SEL_TOP_CODE));
        configure(top, sel_word);
    endtask

    task automatic test_commands_at_reset();
        configure('1, VALUE_WIDTH'(SEL_DIV1));
        send_request(KIND_TICK, '0);
        send_request(KIND_TICK, '1);
        send_request(KIND_TICK, 32'h7FFF_FFFF);
        send_request(KIND_PAUSE, 32'h8000_0000);
        send_request(KIND_TICK, '0);
        send_request(KIND_RESUME, '0);
        send_request(KIND_TICK, '0);
        send_request(KIND_DISARM, '1);
        send_request(KIND_WIDTH'(KIND_DISARM + 1), 32'h7FFF_FFFF);
        send_request(KIND_WIDTH'(KIND_DISARM + 2), 32'h8000_0000);
        send_request(KIND_TOP_CODE, '0);
        settle();
    endtask

    // compare dropped below the counter: it runs on past the compare value
    // without a match
    task automatic test_wrap_past_compare();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(VALUE_WIDTH'(40), VALUE_WIDTH'(SEL_DIV1));
        send_request(KIND_ARM, '1);
        repeat (20) send_request(KIND_TICK, $urandom());
        settle();
        configure(VALUE_WIDTH'(2), VALUE_WIDTH'(SEL_DIV1));
        repeat (30) send_request(KIND_TICK, $urandom());
        settle();
    endtask

    task automatic test_repeat_counts();
        configure('0, VALUE_WIDTH'(SEL_DIV1));
        send_request(KIND_ARM, REPEAT_WIDTH'(2));
        repeat (3) send_request(KIND_TICK, '0);
        send_request(KIND_TICK, '0);
        send_request(KIND_ARM, '1);
        repeat (2) send_request(KIND_TICK, '0);
        send_request(KIND_ARM, 32'h8000_0000);
        repeat (2) send_request(KIND_TICK, '0);
        send_request(KIND_ARM, '0);
        send_request(KIND_TICK, '0);
        send_request(KIND_ARM, 32'h7FFF_FFFF);
        send_request(KIND_TICK, '0);
        send_request(KIND_DISARM, '0);
        send_request(KIND_TICK, '0);
        settle();
    endtask

    task automatic test_prescaler_switch();
        configure(VALUE_WIDTH'(5), VALUE_WIDTH'(SEL_DIV1024));
        send_request(KIND_ARM, '1);
        repeat (12) send_request(KIND_TICK, '0);
        settle();
        // prescaler already past the last div8 step
        configure(VALUE_WIDTH'(5), VALUE_WIDTH'(SEL_DIV8));
        repeat (3) send_request(KIND_TICK, '0);
        settle();
        configure(VALUE_WIDTH'(5), VALUE_WIDTH'(SEL_STOP));
        send_request(KIND_TICK, '0);
        settle();
        configure(VALUE_WIDTH'(5), VALUE_WIDTH'(SEL_SPARE));
        send_request(KIND_TICK, '0);
        settle();
        configure(VALUE_WIDTH'(5), VALUE_WIDTH'(SEL_TOP_CODE));
        send_request(KIND_TICK, '0);
        settle();
    endtask

    task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct);
        int sent;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n)
        begin
            random_settings();
            repeat (PHASE_CHUNK) send_random_request();
            sent += PHASE_CHUNK;
            settle();
        end
    endtask

    // results held back for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(VALUE_WIDTH'(3), VALUE_WIDTH'(SEL_DIV1));
        stall_burst = HOLD_CYCLES;
        repeat (150) send_random_request();
        settle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_commands_at_reset();
        test_wrap_past_compare();
        test_repeat_counts();
        test_prescaler_switch();
        test_random_traffic(420, 0, 0);
        test_random_traffic(420, 66, 0);
        test_random_traffic(420, 0, 66);
        test_random_traffic(420, 25, 25);
        test_output_backpressure();
        settle();
        if (mismatches == 0)
            $display("tb_ctc_timer_with_repeat_count passed");
        else
            $display("tb_ctc_timer_with_repeat_count failed");
        $finish;
    end

endmodule
